[hdl/bfp_pkg.sv]
// bfp_pkg: shared constants, types and field decode for the box frame parser
// no dependencies; used by box_frame_parser
`timescale 1ns / 1ps
`default_nettype none

package bfp_pkg;

   localparam int MAX_PAYLOAD = 50;
   localparam int FRAME_LEN   = 16;
   localparam int COUNT_W     = 6;
   localparam int HEAD_IDX_W  = $clog2(FRAME_LEN);
   localparam int FIELD_LEN   = 3;
   localparam int NUM_CORNERS = 4;
   localparam int COORD_W     = 11;
   localparam int AREA_W      = 17;
   localparam int QUOT_W      = 7;

   // floor(d / 10) == (d * 1639) >> 14 for every d below 2730
   localparam int DIV10_MUL   = 1639;
   localparam int DIV10_SHIFT = 14;
   localparam int DIV10_PROD_W = 2 * COORD_W;

   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_HASH   = 8'h23;
   localparam logic [7:0] CHAR_COMMA  = 8'h2c;
   localparam logic [7:0] CHAR_PLUS   = 8'h2b;
   localparam logic [7:0] CHAR_MINUS  = 8'h2d;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_CR     = 8'h0d;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_FORMAT = 2'd1,
      STATUS_ORDER  = 2'd2
   } status_type;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [AREA_W-1:0]         area_type;
   typedef logic [FIELD_LEN-1:0][7:0] field_type;

   function automatic logic is_space(input logic [7:0] c);
      return c inside {CHAR_SPACE, [CHAR_TAB:CHAR_CR]};
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c inside {[CHAR_ZERO:CHAR_NINE]};
   endfunction

   // atoi over a three-character field: whitespace, optional sign, digits
   function automatic coord_type decode_field(input field_type p);
      logic       in_digits;
      logic       done;
      logic       neg;
      logic [9:0] v;
      logic [13:0] acc;
      coord_type  mag;
      in_digits = 1'b0;
      done      = 1'b0;
      neg       = 1'b0;
      v         = '0;
      for (int k = 0; k < FIELD_LEN; k++) begin
         acc = 14'(v) * 14'd10 + 14'(p[k][3:0]);
         if (!done) begin
            if (!in_digits && is_space(p[k])) begin
               in_digits = 1'b0;
            end else if (!in_digits && (p[k] == CHAR_PLUS || p[k] == CHAR_MINUS)) begin
               neg       = (p[k] == CHAR_MINUS);
               in_digits = 1'b1;
            end else if (is_digit(p[k])) begin
               v         = acc[9:0];
               in_digits = 1'b1;
            end else begin
               done = 1'b1;
            end
         end
      end
      mag = $signed({1'b0, v});
      return neg ? -mag : mag;
   endfunction

endpackage

`default_nettype wire

[hdl/box_frame_parser.sv]
// box_frame_parser: byte stream parser for $aaa,bbb,ccc,ddd,# bounding-box frames
// depends on bfp_pkg
//
// usage:
//   req channel: one received byte per beat (req_valid / req_stall / req_rx_byte)
//   rsp channel: one result beat per '#' that closes an open frame, carrying the
//     status and the stored corners, center and area after that frame
//   a byte is taken in every cycle unless the result register is full and
//     stalled; any number of bytes may follow each other back to back
//   a result is registered in turn by the decode register, the difference /
//     divide-by-ten register and the result register after its '#' is accepted
//   throughput: one byte per unstalled cycle; at most one result per two bytes
//   reset: synchronous, active high; closes any frame and clears the stored
//     corners, center and area to zero; no clearing sweep, ready at once
//   rsp_stall: the whole pipeline holds and req_stall is raised until the
//     result beat is taken; a stalled result keeps its value
//   bad format leaves all stored values untouched; corners out of order update
//     the corners but keep center and area
`timescale 1ns / 1ps
`default_nettype none

module box_frame_parser (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [7:0]           req_rx_byte,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output bfp_pkg::status_type       rsp_status,
   output bfp_pkg::coord_type        rsp_left_x,
   output bfp_pkg::coord_type        rsp_top_y,
   output bfp_pkg::coord_type        rsp_right_x,
   output bfp_pkg::coord_type        rsp_bottom_y,
   output bfp_pkg::coord_type        rsp_center_x,
   output bfp_pkg::coord_type        rsp_center_y,
   output bfp_pkg::area_type         rsp_box_area
);
   import bfp_pkg::*;

   logic advance;
   logic accept;

   // byte-level frame state
   logic               in_frame_ff, in_frame_in;
   logic [COUNT_W-1:0] byte_count_ff, byte_count_in;
   logic               zero_seen_ff, zero_seen_in;
   logic [COUNT_W-1:0] first_zero_ff, first_zero_in;
   logic [7:0]         head_ff [FRAME_LEN];
   logic               head_we;
   logic               close_in;

   // decode stage
   logic       len_ok;
   logic       comma_ok;
   coord_type  dec_corner [NUM_CORNERS];
   logic       s1_valid_ff;
   logic       s1_fmt_ok_ff;
   coord_type  s1_corner_ff [NUM_CORNERS];

   // difference stage
   logic signed [COORD_W:0]  dx_full, dy_full;
   logic                     order_bad;
   status_type               s2_status_in;
   logic [DIV10_PROD_W-1:0]  div_prod;
   logic                     s2_valid_ff;
   status_type               s2_status_ff;
   coord_type                s2_corner_ff [NUM_CORNERS];
   logic [COORD_W-1:0]       s2_dx_ff, s2_dy_ff;
   logic [QUOT_W-1:0]        s2_quot_ff;

   // result stage, also the stored values
   logic signed [COORD_W:0]  cx_sum, cy_sum;
   logic [AREA_W:0]          area_prod;
   logic                     rsp_valid_ff;
   status_type               rsp_status_ff;
   coord_type                corner_ff [NUM_CORNERS];
   coord_type                center_x_ff, center_y_ff;
   area_type                 box_area_ff;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign accept    = req_valid && advance;

   always_comb begin
      in_frame_in   = in_frame_ff;
      byte_count_in = byte_count_ff;
      zero_seen_in  = zero_seen_ff;
      first_zero_in = first_zero_ff;
      head_we       = 1'b0;
      close_in      = 1'b0;
      if (accept) begin
         if (!in_frame_ff) begin
            if (req_rx_byte == CHAR_DOLLAR) begin
               in_frame_in   = 1'b1;
               byte_count_in = '0;
               zero_seen_in  = 1'b0;
               first_zero_in = '0;
            end
         end else if (req_rx_byte == CHAR_HASH || req_rx_byte == CHAR_DOLLAR ||
                      byte_count_ff >= COUNT_W'(MAX_PAYLOAD)) begin
            close_in      = (req_rx_byte == CHAR_HASH);
            in_frame_in   = 1'b0;
            byte_count_in = '0;
            zero_seen_in  = 1'b0;
            first_zero_in = '0;
         end else begin
            head_we       = (byte_count_ff < COUNT_W'(FRAME_LEN));
            byte_count_in = byte_count_ff + COUNT_W'(1);
            if (req_rx_byte == 8'h00 && !zero_seen_ff) begin
               zero_seen_in  = 1'b1;
               first_zero_in = byte_count_ff;
            end
         end
      end
   end

   // frame check and field decode on the stored head
   always_comb begin
      len_ok = zero_seen_ff ? (first_zero_ff == COUNT_W'(FRAME_LEN))
                            : (byte_count_ff == COUNT_W'(FRAME_LEN));
      comma_ok = 1'b1;
      for (int i = 0; i < FRAME_LEN; i++) begin
         if ((head_ff[i] == CHAR_COMMA) != ((i & 3) == 3)) begin
            comma_ok = 1'b0;
         end
      end
      for (int k = 0; k < NUM_CORNERS; k++) begin
         dec_corner[k] = decode_field({head_ff[4*k+2], head_ff[4*k+1], head_ff[4*k]});
      end
   end

   always_comb begin
      dx_full   = (COORD_W+1)'(s1_corner_ff[2]) - (COORD_W+1)'(s1_corner_ff[0]);
      dy_full   = (COORD_W+1)'(s1_corner_ff[3]) - (COORD_W+1)'(s1_corner_ff[1]);
      order_bad = (s1_corner_ff[0] > s1_corner_ff[2]) || (s1_corner_ff[1] > s1_corner_ff[3]);
      div_prod  = DIV10_PROD_W'(dx_full[COORD_W-1:0]) * DIV10_PROD_W'(DIV10_MUL);
      if (!s1_fmt_ok_ff) begin
         s2_status_in = STATUS_FORMAT;
      end else if (order_bad) begin
         s2_status_in = STATUS_ORDER;
      end else begin
         s2_status_in = STATUS_OK;
      end
   end

   always_comb begin
      cx_sum    = $signed({2'b00, s2_dx_ff[COORD_W-1:1]}) + (COORD_W+1)'(s2_corner_ff[0]);
      cy_sum    = $signed({2'b00, s2_dy_ff[COORD_W-1:1]}) + (COORD_W+1)'(s2_corner_ff[1]);
      area_prod = (AREA_W+1)'(s2_quot_ff) * (AREA_W+1)'(s2_dy_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff   <= 1'b0;
         byte_count_ff <= '0;
         zero_seen_ff  <= 1'b0;
         first_zero_ff <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rsp_status_ff <= STATUS_OK;
         for (int k = 0; k < NUM_CORNERS; k++) begin
            corner_ff[k] <= '0;
         end
         center_x_ff <= '0;
         center_y_ff <= '0;
         box_area_ff <= '0;
      end else begin
         in_frame_ff   <= in_frame_in;
         byte_count_ff <= byte_count_in;
         zero_seen_ff  <= zero_seen_in;
         first_zero_ff <= first_zero_in;
         if (advance) begin
            s1_valid_ff  <= close_in;
            s2_valid_ff  <= s1_valid_ff;
            rsp_valid_ff <= s2_valid_ff;
            if (s2_valid_ff) begin
               rsp_status_ff <= s2_status_ff;
               if (s2_status_ff != STATUS_FORMAT) begin
                  for (int k = 0; k < NUM_CORNERS; k++) begin
                     corner_ff[k] <= s2_corner_ff[k];
                  end
               end
               if (s2_status_ff == STATUS_OK) begin
                  center_x_ff <= cx_sum[COORD_W-1:0];
                  center_y_ff <= cy_sum[COORD_W-1:0];
                  box_area_ff <= area_prod[AREA_W-1:0];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (head_we) begin
         head_ff[byte_count_ff[HEAD_IDX_W-1:0]] <= req_rx_byte;
      end
      if (advance) begin
         s1_fmt_ok_ff <= len_ok && comma_ok;
         for (int k = 0; k < NUM_CORNERS; k++) begin
            s1_corner_ff[k] <= dec_corner[k];
            s2_corner_ff[k] <= s1_corner_ff[k];
         end
         s2_status_ff <= s2_status_in;
         s2_dx_ff     <= dx_full[COORD_W-1:0];
         s2_dy_ff     <= dy_full[COORD_W-1:0];
         s2_quot_ff   <= div_prod[DIV10_SHIFT +: QUOT_W];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_left_x   = corner_ff[0];
   assign rsp_top_y    = corner_ff[1];
   assign rsp_right_x  = corner_ff[2];
   assign rsp_bottom_y = corner_ff[3];
   assign rsp_center_x = center_x_ff;
   assign rsp_center_y = center_y_ff;
   assign rsp_box_area = box_area_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      byte_count_ff <= COUNT_W'(MAX_PAYLOAD))
      else $error("payload count past limit");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      !in_frame_ff |-> (byte_count_ff == '0 && !zero_seen_ff))
      else $error("frame state left over outside a frame");

   a_zero_pos: assert property (@(posedge clock) disable iff (reset)
      zero_seen_ff |-> (first_zero_ff < byte_count_ff))
      else $error("first zero position beyond payload count");

   a_close_token: assert property (@(posedge clock) disable iff (reset)
      (accept && in_frame_ff && req_rx_byte == CHAR_HASH) |=> s1_valid_ff)
      else $error("closing beat lost before decode stage");

   a_format_keeps: assert property (@(posedge clock) disable iff (reset)
      (advance && s2_valid_ff && s2_status_ff == STATUS_FORMAT) |=>
         (corner_ff[0] == $past(corner_ff[0]) && center_x_ff == $past(center_x_ff) &&
          box_area_ff == $past(box_area_ff)))
      else $error("bad frame changed stored values");
`endif

endmodule

`default_nettype wire
